@@ hdl/pce_pkg.sv @@
// ----------------------------------------------------------------------------
// Pixel color effect package
// Shared types, register codes and arithmetic helpers for the effect datapath.
// ----------------------------------------------------------------------------
package pce_pkg;

  typedef enum logic [1:0] {
    MODE_OPACITY   = 2'd0,
    MODE_GRAYSCALE = 2'd1,
    MODE_NEGATIVE  = 2'd2,
    MODE_SEPIA     = 2'd3
  } effect_mode_t;

  localparam int unsigned CfgAddrWidth = 3;
  localparam logic REG_EFFECT_MODE   = 1'b0;
  localparam logic REG_OPACITY_LEVEL = 1'b1;
  localparam logic [7:0] OpacityReset = 8'hFF;

  typedef struct packed {
    logic [7:0] alpha_in;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       frame_end_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] alpha_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end_out;
  } pixel_out_t;

  // Division by 1000 is a multiplication by a scaled reciprocal. The weights
  // are folded into the reciprocal, so one product level forms the quotient.
  localparam int unsigned DivShift = 28;
  localparam int unsigned Recip    = ((1 << DivShift) + 999) / 1000;
  localparam int unsigned SumWidth = 37;
  localparam int unsigned KWidth   = 28;

  localparam logic [KWidth-1:0] K_GRAY_R  = KWidth'(299 * Recip);
  localparam logic [KWidth-1:0] K_GRAY_G  = KWidth'(587 * Recip);
  localparam logic [KWidth-1:0] K_GRAY_B  = KWidth'(114 * Recip);
  localparam logic [KWidth-1:0] K_SEP_RR  = KWidth'(393 * Recip);
  localparam logic [KWidth-1:0] K_SEP_RG  = KWidth'(769 * Recip);
  localparam logic [KWidth-1:0] K_SEP_RB  = KWidth'(189 * Recip);
  localparam logic [KWidth-1:0] K_SEP_GR  = KWidth'(349 * Recip);
  localparam logic [KWidth-1:0] K_SEP_GG  = KWidth'(686 * Recip);
  localparam logic [KWidth-1:0] K_SEP_GB  = KWidth'(168 * Recip);
  localparam logic [KWidth-1:0] K_SEP_BR  = KWidth'(272 * Recip);
  localparam logic [KWidth-1:0] K_SEP_BG  = KWidth'(534 * Recip);
  localparam logic [KWidth-1:0] K_SEP_BB  = KWidth'(131 * Recip);

  // Returns floor(weighted sum / 1000) as a 9-bit quotient; exact below 256.
  function automatic logic [8:0] dot_div(
    input logic [7:0]        r,
    input logic [7:0]        g,
    input logic [7:0]        b,
    input logic [KWidth-1:0] kr,
    input logic [KWidth-1:0] kg,
    input logic [KWidth-1:0] kb
  );
    logic [SumWidth-1:0] sum;
    sum = SumWidth'(r) * SumWidth'(kr) + SumWidth'(g) * SumWidth'(kg)
        + SumWidth'(b) * SumWidth'(kb);
    return sum[SumWidth-1:DivShift];
  endfunction

  function automatic logic [7:0] sat8(input logic [8:0] v);
    return v[8] ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [16:0] x;
    logic [16:0] y;
    x = 17'(c) * 17'(a);
    y = x + 17'((x + 17'd257) >> 8);
    return y[15:8];
  endfunction

endpackage

@@ hdl/pce_effect.sv @@
// ----------------------------------------------------------------------------
// Pixel color effect datapath
// Applies the selected opacity, grayscale, negative or sepia effect to a pixel.
// ----------------------------------------------------------------------------
module pce_effect import pce_pkg::*; (
  input  effect_mode_t mode,
  input  logic [7:0]   opacity,
  input  pixel_in_t    pix_i,
  output pixel_out_t   pix_o
);

  logic [7:0] gray;

  assign gray = sat8(dot_div(pix_i.red_in, pix_i.green_in, pix_i.blue_in,
                             K_GRAY_R, K_GRAY_G, K_GRAY_B));

  always_comb begin
    pix_o.alpha_out     = pix_i.alpha_in;
    pix_o.red_out       = pix_i.red_in;
    pix_o.green_out     = pix_i.green_in;
    pix_o.blue_out      = pix_i.blue_in;
    pix_o.frame_end_out = pix_i.frame_end_in;
    unique case (mode)
      MODE_OPACITY: begin
        if (opacity != 8'hFF) begin
          pix_o.alpha_out = opacity;
          pix_o.red_out   = premul(pix_i.red_in, opacity);
          pix_o.green_out = premul(pix_i.green_in, opacity);
          pix_o.blue_out  = premul(pix_i.blue_in, opacity);
        end
      end
      MODE_GRAYSCALE: begin
        pix_o.red_out   = gray;
        pix_o.green_out = gray;
        pix_o.blue_out  = gray;
      end
      MODE_NEGATIVE: begin
        pix_o.red_out   = ~pix_i.red_in;
        pix_o.green_out = ~pix_i.green_in;
        pix_o.blue_out  = ~pix_i.blue_in;
      end
      MODE_SEPIA: begin
        pix_o.red_out   = sat8(dot_div(pix_i.red_in, pix_i.green_in, pix_i.blue_in,
                                       K_SEP_RR, K_SEP_RG, K_SEP_RB));
        pix_o.green_out = sat8(dot_div(pix_i.red_in, pix_i.green_in, pix_i.blue_in,
                                       K_SEP_GR, K_SEP_GG, K_SEP_GB));
        pix_o.blue_out  = sat8(dot_div(pix_i.red_in, pix_i.green_in, pix_i.blue_in,
                                       K_SEP_BR, K_SEP_BG, K_SEP_BB));
      end
      default: begin
        pix_o.red_out = pix_i.red_in;
      end
    endcase
  end

endmodule

@@ hdl/pixel_color_effect.sv @@
// ----------------------------------------------------------------------------
// Pixel color effect
// Stateless per-pixel effect on an ARGB stream, selected by a register.
// ----------------------------------------------------------------------------
// Channel   Handshake                     Payload
// input     start (busy is always low)    in_pixel
// result    out_strobe, one cycle         out_pixel
// config    psel/penable/pwrite/pready    paddr, pwdata, prdata
//
// One pixel is taken in every cycle. Its result passes the input register and
// then the result register before it reaches the result ports.
// Reset returns effect_mode to opacity and opacity_level to 255.
// The receiver cannot stall, so the block never raises busy.
// ----------------------------------------------------------------------------
module pixel_color_effect import pce_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  pixel_in_t               in_pixel,
  output logic                    out_strobe,
  output pixel_out_t              out_pixel,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  effect_mode_t mode_r;
  logic [7:0]   opacity_r;
  logic         in_valid_r;
  pixel_in_t    in_pixel_r;
  logic         out_strobe_r;
  pixel_out_t   out_pixel_r;
  pixel_out_t   out_pixel_nxt;
  logic         cfg_write;

  assign busy      = 1'b0;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_OPACITY;
      opacity_r <= OpacityReset;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_EFFECT_MODE:   mode_r    <= effect_mode_t'(pwdata[1:0]);
        REG_OPACITY_LEVEL: opacity_r <= pwdata[7:0];
        default:           mode_r    <= mode_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_EFFECT_MODE:   prdata = {30'd0, mode_r};
      REG_OPACITY_LEVEL: prdata = {24'd0, opacity_r};
      default:           prdata = 32'd0;
    endcase
  end

  pce_effect u_effect (
    .mode    (mode_r),
    .opacity (opacity_r),
    .pix_i   (in_pixel_r),
    .pix_o   (out_pixel_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      in_valid_r   <= start;
      out_strobe_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    in_pixel_r  <= in_pixel;
    out_pixel_r <= out_pixel_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_pixel  = out_pixel_r;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pixel color effect testbench
// Streams ARGB pixels through every effect under directed and random register settings, predicts
// each result pixel in order and compares it field by field with the block.
// ----------------------------------------------------------------------------
module tb_top;
  import pce_pkg::*;

  localparam logic [CfgAddrWidth-1:0] ADDR_EFFECT_MODE   =
    CfgAddrWidth'({REG_EFFECT_MODE, 2'b00});
  localparam logic [CfgAddrWidth-1:0] ADDR_OPACITY_LEVEL =
    CfgAddrWidth'({REG_OPACITY_LEVEL, 2'b00});
  localparam int unsigned RANDOM_PIXELS  = 1200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 10;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  pixel_in_t               in_pixel;
  logic                    out_strobe;
  pixel_out_t              out_pixel;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CfgAddrWidth-1:0] paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  effect_mode_t mode_shadow;
  logic [7:0]   opacity_shadow;
  pixel_out_t   expected_pixels[$];
  int unsigned  errors;
  int unsigned  pixels_sent;
  int unsigned  settings_applied;
  int unsigned  pixels_per_mode[4];
  int unsigned  idle_cycles;

  pixel_color_effect dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_pixel(in_pixel),
    .out_strobe(out_strobe),
    .out_pixel(out_pixel),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] scale_by_opacity(input logic [7:0] c);
    int unsigned x;
    x = c * opacity_shadow;
    return 8'((x + ((x + 257) >> 8)) >> 8);
  endfunction

  function automatic logic [7:0] weighted_level(
    input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
    input int unsigned wr, input int unsigned wg, input int unsigned wb
  );
    int unsigned s;
    s = (wr * r + wg * g + wb * b) / 1000;
    return (s > 255) ? 8'hFF : 8'(s);
  endfunction

  function automatic pixel_out_t predict_effect(input pixel_in_t p);
    pixel_out_t q;
    q.alpha_out     = p.alpha_in;
    q.red_out       = p.red_in;
    q.green_out     = p.green_in;
    q.blue_out      = p.blue_in;
    q.frame_end_out = p.frame_end_in;
    case (mode_shadow)
      MODE_OPACITY: begin
        if (opacity_shadow != 8'hFF) begin
          q.alpha_out = opacity_shadow;
          q.red_out   = scale_by_opacity(p.red_in);
          q.green_out = scale_by_opacity(p.green_in);
          q.blue_out  = scale_by_opacity(p.blue_in);
        end
      end
      MODE_GRAYSCALE: begin
        q.red_out   = weighted_level(p.red_in, p.green_in, p.blue_in, 299, 587, 114);
        q.green_out = q.red_out;
        q.blue_out  = q.red_out;
      end
      MODE_NEGATIVE: begin
        q.red_out   = 8'hFF - p.red_in;
        q.green_out = 8'hFF - p.green_in;
        q.blue_out  = 8'hFF - p.blue_in;
      end
      default: begin
        q.red_out   = weighted_level(p.red_in, p.green_in, p.blue_in, 393, 769, 189);
        q.green_out = weighted_level(p.red_in, p.green_in, p.blue_in, 349, 686, 168);
        q.blue_out  = weighted_level(p.red_in, p.green_in, p.blue_in, 272, 534, 131);
      end
    endcase
    return q;
  endfunction

  function automatic pixel_in_t make_pixel(
    input logic [7:0] a, input logic [7:0] r, input logic [7:0] g,
    input logic [7:0] b, input logic fe
  );
    pixel_in_t p;
    p.alpha_in     = a;
    p.red_in       = r;
    p.green_in     = g;
    p.blue_in      = b;
    p.frame_end_in = fe;
    return p;
  endfunction

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    pixel_out_t exp_pixel;
    if (rst_n && out_strobe) begin
      if (expected_pixels.size() == 0) begin
        $error("result pixel arrived with no transfer pending");
        errors++;
      end else begin
        exp_pixel = expected_pixels.pop_front();
        check_field("alpha_out", exp_pixel.alpha_out, out_pixel.alpha_out);
        check_field("red_out", exp_pixel.red_out, out_pixel.red_out);
        check_field("green_out", exp_pixel.green_out, out_pixel.green_out);
        check_field("blue_out", exp_pixel.blue_out, out_pixel.blue_out);
        check_field("frame_end_out", exp_pixel.frame_end_out, out_pixel.frame_end_out);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d result pixels pending.", expected_pixels.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_pixel(input pixel_in_t p);
    start    <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (busy);
    expected_pixels.push_back(predict_effect(p));
    pixels_per_mode[mode_shadow]++;
    pixels_sent++;
  endtask

  task automatic wait_drain();
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CfgAddrWidth-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_registers();
    logic [31:0] rdata;
    cfg_access(1'b0, ADDR_EFFECT_MODE, 32'h0, rdata);
    check_field("effect_mode readback", 32'(mode_shadow), rdata);
    cfg_access(1'b0, ADDR_OPACITY_LEVEL, 32'h0, rdata);
    check_field("opacity_level readback", 32'(opacity_shadow), rdata);
  endtask

  // Upper bits of each write carry random noise; only the low bits land.
  task automatic set_effect(input effect_mode_t mode, input logic [7:0] opacity);
    logic [31:0] wdata;
    logic [31:0] rdata;
    wait_drain();
    wdata      = $urandom;
    wdata[1:0] = mode;
    cfg_access(1'b1, ADDR_EFFECT_MODE, wdata, rdata);
    mode_shadow = mode;
    wdata      = $urandom;
    wdata[7:0] = opacity;
    cfg_access(1'b1, ADDR_OPACITY_LEVEL, wdata, rdata);
    opacity_shadow = opacity;
    settings_applied++;
    check_registers();
  endtask

  task automatic send_directed_set();
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_pixel(make_pixel(8'h80, 8'hFF, 8'h00, 8'h7F, 1'b0));
    start <= 1'b0;
    @(posedge clk);
    send_pixel(make_pixel(8'h01, 8'h00, 8'hFF, 8'h01, 1'b1));
    start <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    check_registers();
    send_pixel(make_pixel(8'h5A, 8'hA5, 8'h3C, 8'hC3, 1'b0));
    send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1));
    start <= 1'b0;
  endtask

  task automatic test_opacity_extremes();
    set_effect(MODE_OPACITY, 8'h00);
    send_directed_set();
    set_effect(MODE_OPACITY, 8'hFE);
    send_directed_set();
  endtask

  task automatic test_each_effect();
    set_effect(MODE_GRAYSCALE, 8'h00);
    send_directed_set();
    set_effect(MODE_NEGATIVE, 8'hFF);
    send_directed_set();
    set_effect(MODE_SEPIA, 8'h80);
    send_directed_set();
  endtask

  // Bursts of pixels under random settings, in frames that may span bursts, with a little marker noise.
  task automatic test_random_stream();
    int unsigned  sent;
    int unsigned  burst_len;
    int unsigned  frame_left;
    int unsigned  gap;
    bit           no_idle;
    logic         fe;
    logic [7:0]   opacity;
    sent = 0;
    frame_left = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 5))
        0:       opacity = 8'h00;
        1:       opacity = 8'hFF;
        2:       opacity = 8'hFE;
        3:       opacity = 8'h01;
        default: opacity = 8'($urandom);
      endcase
      set_effect(effect_mode_t'($urandom_range(0, 3)), opacity);
      burst_len = $urandom_range(16, 120);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (burst_len) begin
        if (frame_left == 0) frame_left = $urandom_range(1, 24);
        fe = (frame_left == 1);
        if ($urandom_range(0, 19) == 0) fe = $urandom_range(0, 1);
        frame_left--;
        send_pixel(make_pixel(rand_channel(), rand_channel(), rand_channel(),
                              rand_channel(), fe));
        sent++;
        if (sent % 300 == 150) begin
          start <= 1'b0;
          wait_drain();
        end else if (!no_idle) begin
          gap = rand_gap();
          if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
      start <= 1'b0;
    end
  endtask

  initial begin
    errors           = 0;
    pixels_sent      = 0;
    settings_applied = 0;
    idle_cycles      = 0;
    pixels_per_mode  = '{default: 0};
    mode_shadow      = MODE_OPACITY;
    opacity_shadow   = OpacityReset;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_pixel <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_opacity_extremes();
    test_each_effect();
    test_random_stream();

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("%0d result pixels never arrived", expected_pixels.size());
      errors++;
    end
    $display("Sent %0d pixels under %0d register settings with both frame marker values.",
             pixels_sent, settings_applied);
    $display("Pixels per effect: opacity %0d, grayscale %0d, negative %0d, sepia %0d.",
             pixels_per_mode[0], pixels_per_mode[1], pixels_per_mode[2],
             pixels_per_mode[3]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
